[src/att_pkg.sv]
// Package: shared constants, types and helpers for the ANSI text terminal.
package att_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int MAX_PARAMS = 10;
    localparam int CELLS      = ROWS * COLUMNS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int PIDX_W = $clog2(MAX_PARAMS);
    localparam int PCNT_W = $clog2(MAX_PARAMS + 1);
    localparam int PAR_W  = 14;
    localparam int CELL_W = 16;

    localparam logic [7:0] ESC_BYTE       = 8'h1b;
    localparam logic [7:0] WHITE_ON_BLACK = 8'h0f;
    localparam logic [7:0] SPACE_BYTE     = 8'h20;
    localparam logic [PAR_W-1:0] PARAM_LIMIT = PAR_W'(9999);

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_ESC    = 2'd1;
    localparam logic [1:0] MODE_PARAM  = 2'd2;

    typedef enum logic [3:0] {
        S_INIT,      // clearing pass after reset
        S_IDLE,
        S_READ,      // wait for RAM read data
        S_RESULT,    // result held until taken
        S_SC_RD,     // scroll: read source cell
        S_SC_WR,     // scroll: write one row up
        S_FILL,      // write blanks over a range
        S_M_RD,      // colour list: fetch parameter
        S_M_AP,      // colour list: apply parameter
        S_H_RD0,
        S_H_RD1,
        S_H_AP,
        S_J_RD,
        S_J_AP
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic                   ram_we;
        logic [ADDR_W-1:0]      ram_waddr;
        logic [CELL_W-1:0]      ram_wdata;
        logic [ADDR_W-1:0]      ram_raddr;
        logic                   par_we;
        logic [PIDX_W-1:0]      par_waddr;
        logic [PAR_W-1:0]       par_wdata;
        logic [PIDX_W-1:0]      par_raddr;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [CELL_W-1:0]      ram_rdata;
        logic [PAR_W-1:0]       par_rdata;
    } t_dp_stat;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(row * COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

[src/att_if.sv]
// Interfaces: valid/ready item channels for requests and results.
interface att_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [7:0]                    char_byte;
    logic [10:0]                   cell_index;
    modport source (output valid, req_type, char_byte, cell_index, input ready);
    modport sink   (input valid, req_type, char_byte, cell_index, output ready);
endinterface

interface att_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [15:0]                   cell_data;
    logic [10:0]                   cursor_index;
    logic                          in_escape;
    modport source (output valid, cell_data, cursor_index, in_escape, input ready);
    modport sink   (input valid, cell_data, cursor_index, in_escape, output ready);
endinterface

[src/att_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module att_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/att_datapath.sv]
// Datapath: screen memory and parameter store.
module att_datapath (
    input  logic              i_clk,
    input  att_pkg::t_dp_cmd  i_cmd,
    output att_pkg::t_dp_stat o_stat
);
    att_ram #(.WIDTH(att_pkg::CELL_W), .DEPTH(att_pkg::CELLS)) u_screen (
        .i_clk  (i_clk),
        .i_we   (i_cmd.ram_we),
        .i_waddr(i_cmd.ram_waddr),
        .i_wdata(i_cmd.ram_wdata),
        .i_raddr(i_cmd.ram_raddr),
        .o_rdata(o_stat.ram_rdata)
    );

    att_ram #(.WIDTH(att_pkg::PAR_W), .DEPTH(att_pkg::MAX_PARAMS)) u_params (
        .i_clk  (i_clk),
        .i_we   (i_cmd.par_we),
        .i_waddr(i_cmd.par_waddr),
        .i_wdata(i_cmd.par_wdata),
        .i_raddr(i_cmd.par_raddr),
        .o_rdata(o_stat.par_rdata)
    );
endmodule

[src/att_ctrl.sv]
// Controller: byte decoder, escape parser, cursor and memory sequencing.
module att_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    att_req_if.sink           req,
    att_rsp_if.source         rsp,
    output att_pkg::t_dp_cmd  o_cmd,
    input  att_pkg::t_dp_stat i_stat
);
    localparam int AW = att_pkg::ADDR_W;
    localparam int CW = att_pkg::COL_W;
    localparam int RW = att_pkg::ROW_W;
    localparam int PW = att_pkg::PAR_W;

    att_pkg::t_state r_state, n_state;
    logic [RW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [7:0]      r_color, n_color;
    logic [1:0]      r_mode, n_mode;
    logic [att_pkg::PCNT_W-1:0] r_pcnt, n_pcnt;
    logic [PW-1:0]   r_acc, n_acc;
    logic            r_seen, n_seen;
    logic [AW-1:0]   r_ptr, n_ptr;      // walk pointer
    logic [AW-1:0]   r_end, n_end;      // last cell of a fill
    logic [att_pkg::PCNT_W-1:0] r_pi, n_pi;
    logic [3:0]      r_fg, n_fg;
    logic [3:0]      r_bg, n_bg;
    logic [PW-1:0]   r_p0, n_p0;
    logic [15:0]     r_data, n_data;
    att_pkg::t_dp_cmd cmd;

    logic [7:0]      c;
    logic [PW+3:0]   acc_mul;
    logic [PW-1:0]   pv;
    logic [CW:0]     tab_col;
    logic [CW:0]     col_inc;
    logic [PW-1:0]   push_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= att_pkg::S_INIT;
            r_row    <= '0;
            r_col    <= '0;
            r_color  <= att_pkg::WHITE_ON_BLACK;
            r_mode   <= att_pkg::MODE_NORMAL;
            r_pcnt   <= '0;
            r_acc    <= '0;
            r_seen   <= 1'b0;
            r_ptr    <= '0;
            r_end    <= AW'(att_pkg::CELLS - 1);
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_color  <= n_color;
            r_mode   <= n_mode;
            r_pcnt   <= n_pcnt;
            r_acc    <= n_acc;
            r_seen   <= n_seen;
            r_ptr    <= n_ptr;
            r_end    <= n_end;
        end
        r_pi   <= n_pi;
        r_fg   <= n_fg;
        r_bg   <= n_bg;
        r_p0   <= n_p0;
        r_data <= n_data;
    end

    assign c        = req.char_byte;
    assign acc_mul  = (PW+4)'(r_acc) * (PW+4)'(10) + (PW+4)'(c - 8'h30);
    assign pv       = i_stat.par_rdata;
    assign tab_col  = ((CW+1)'(r_col) + (CW+1)'(4)) & ~(CW+1)'(3);
    assign col_inc  = (CW+1)'(r_col) + (CW+1)'(1);
    assign push_val = r_seen ? r_acc : '0;

    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_col    = r_col;
        n_color  = r_color;
        n_mode   = r_mode;
        n_pcnt   = r_pcnt;
        n_acc    = r_acc;
        n_seen   = r_seen;
        n_ptr    = r_ptr;
        n_end    = r_end;
        n_pi     = r_pi;
        n_fg     = r_fg;
        n_bg     = r_bg;
        n_p0     = r_p0;
        n_data   = r_data;
        cmd      = '0;
        cmd.ram_raddr = r_ptr;
        cmd.par_raddr = r_pi[att_pkg::PIDX_W-1:0];
        req.ready = 1'b0;

        unique case (r_state)
            att_pkg::S_INIT: begin
                cmd.ram_we    = 1'b1;
                cmd.ram_waddr = r_ptr;
                cmd.ram_wdata = {att_pkg::WHITE_ON_BLACK, att_pkg::SPACE_BYTE};
                n_ptr = r_ptr + AW'(1);
                if (r_ptr == AW'(att_pkg::CELLS - 1)) begin
                    n_state = att_pkg::S_IDLE;
                end
            end
            att_pkg::S_IDLE: begin
                req.ready = 1'b1;
                n_data    = '0;
                if (req.valid) begin
                    n_state = att_pkg::S_RESULT;
                    if (req.req_type) begin
                        cmd.ram_raddr = req.cell_index[AW-1:0];
                        n_state = att_pkg::S_READ;
                    end else if (r_mode == att_pkg::MODE_ESC) begin
                        n_mode = att_pkg::MODE_NORMAL;
                        if (c == 8'h5b) begin
                            n_mode = att_pkg::MODE_PARAM;
                            n_pcnt = '0;
                            n_acc  = '0;
                            n_seen = 1'b0;
                        end
                    end else if (r_mode != att_pkg::MODE_NORMAL) begin
                        if (c >= 8'h30 && c <= 8'h39) begin
                            n_acc  = (acc_mul > (PW+4)'(att_pkg::PARAM_LIMIT))
                                     ? att_pkg::PARAM_LIMIT : acc_mul[PW-1:0];
                            n_seen = 1'b1;
                        end else if (c == 8'h3b || (c >= 8'h40 && c <= 8'h5a) ||
                                     (c >= 8'h61 && c <= 8'h7a)) begin
                            if (r_pcnt < att_pkg::PCNT_W'(att_pkg::MAX_PARAMS)) begin
                                cmd.par_we    = 1'b1;
                                cmd.par_waddr = r_pcnt[att_pkg::PIDX_W-1:0];
                                cmd.par_wdata = push_val;
                                n_pcnt = r_pcnt + att_pkg::PCNT_W'(1);
                            end
                            n_acc  = '0;
                            n_seen = 1'b0;
                            if (c != 8'h3b) begin
                                n_mode = att_pkg::MODE_NORMAL;
                                n_pi   = '0;
                                n_fg   = r_color[3:0];
                                n_bg   = r_color[7:4];
                                if (c == 8'h48) begin
                                    n_state = att_pkg::S_H_RD0;
                                end else if (c == 8'h4a) begin
                                    n_state = att_pkg::S_J_RD;
                                end else if (c == 8'h4b) begin
                                    n_ptr   = att_pkg::cell_addr(r_row, r_col);
                                    n_end   = att_pkg::cell_addr(r_row, CW'(att_pkg::COLUMNS - 1));
                                    n_state = att_pkg::S_FILL;
                                end else if (c == 8'h6d) begin
                                    n_state = att_pkg::S_M_RD;
                                end
                            end
                        end
                    end else if (c == att_pkg::ESC_BYTE) begin
                        n_mode = att_pkg::MODE_ESC;
                    end else if (c == 8'h0a || (c != 8'h09 && c != 8'h08 &&
                                 col_inc >= (CW+1)'(att_pkg::COLUMNS)) ||
                                 (c == 8'h09 && tab_col >= (CW+1)'(att_pkg::COLUMNS))) begin
                        // character at last column, newline or tab past the end
                        if (c != 8'h0a && c != 8'h09) begin
                            cmd.ram_we    = 1'b1;
                            cmd.ram_waddr = att_pkg::cell_addr(r_row, r_col);
                            cmd.ram_wdata = {r_color, c};
                        end
                        n_col = '0;
                        if (r_row == RW'(att_pkg::ROWS - 1)) begin
                            n_ptr   = AW'(att_pkg::COLUMNS);
                            n_state = att_pkg::S_SC_RD;
                        end else begin
                            n_row = r_row + RW'(1);
                        end
                    end else if (c == 8'h09) begin
                        n_col = tab_col[CW-1:0];
                    end else if (c == 8'h08) begin
                        if (r_col == '0) begin
                            if (r_row != '0) begin
                                n_row = r_row - RW'(1);
                            end
                            n_col = CW'(att_pkg::COLUMNS - 1);
                        end else begin
                            n_col = r_col - CW'(1);
                        end
                        cmd.ram_we    = 1'b1;
                        cmd.ram_waddr = att_pkg::cell_addr(n_row, n_col);
                        cmd.ram_wdata = {r_color, att_pkg::SPACE_BYTE};
                    end else begin
                        cmd.ram_we    = 1'b1;
                        cmd.ram_waddr = att_pkg::cell_addr(r_row, r_col);
                        cmd.ram_wdata = {r_color, c};
                        n_col = col_inc[CW-1:0];
                    end
                    if (req.req_type && req.cell_index >= 11'(att_pkg::CELLS)) begin
                        n_state = att_pkg::S_RESULT;
                    end
                end
            end
            att_pkg::S_READ: begin
                n_data  = i_stat.ram_rdata;
                n_state = att_pkg::S_RESULT;
            end
            att_pkg::S_RESULT: begin
                if (rsp.ready) begin
                    n_state = att_pkg::S_IDLE;
                end
            end
            att_pkg::S_SC_RD: begin
                n_state = att_pkg::S_SC_WR;
            end
            att_pkg::S_SC_WR: begin
                cmd.ram_we    = 1'b1;
                cmd.ram_waddr = r_ptr - AW'(att_pkg::COLUMNS);
                cmd.ram_wdata = i_stat.ram_rdata;
                if (r_ptr == AW'(att_pkg::CELLS - 1)) begin
                    n_ptr   = AW'((att_pkg::ROWS - 1) * att_pkg::COLUMNS);
                    n_end   = AW'(att_pkg::CELLS - 1);
                    n_state = att_pkg::S_FILL;
                end else begin
                    n_ptr   = r_ptr + AW'(1);
                    n_state = att_pkg::S_SC_RD;
                end
            end
            att_pkg::S_FILL: begin
                cmd.ram_we    = 1'b1;
                cmd.ram_waddr = r_ptr;
                cmd.ram_wdata = {r_color, att_pkg::SPACE_BYTE};
                n_ptr = r_ptr + AW'(1);
                if (r_ptr == r_end) begin
                    n_state = att_pkg::S_RESULT;
                end
            end
            att_pkg::S_M_RD: begin
                if (r_pcnt == '0) begin
                    n_color = att_pkg::WHITE_ON_BLACK;
                    n_state = att_pkg::S_RESULT;
                end else if (r_pi == r_pcnt) begin
                    n_color = {r_bg, r_fg};
                    n_state = att_pkg::S_RESULT;
                end else begin
                    n_state = att_pkg::S_M_AP;
                end
            end
            att_pkg::S_M_AP: begin
                if (pv == '0) begin
                    n_fg = 4'hf;
                    n_bg = '0;
                end else if (pv >= PW'(30) && pv <= PW'(37)) begin
                    n_fg = {1'b0, pv[2:0] - 3'd6};
                end else if (pv >= PW'(40) && pv <= PW'(47)) begin
                    n_bg = {1'b0, pv[2:0]};
                end
                n_pi    = r_pi + att_pkg::PCNT_W'(1);
                n_state = att_pkg::S_M_RD;
            end
            att_pkg::S_H_RD0: begin
                n_pi    = att_pkg::PCNT_W'(1);
                n_state = att_pkg::S_H_RD1;
            end
            att_pkg::S_H_RD1: begin
                n_p0    = (r_pcnt > '0) ? pv : PW'(1);
                n_state = att_pkg::S_H_AP;
            end
            att_pkg::S_H_AP: begin
                if (r_p0 <= PW'(1)) begin
                    n_row = '0;
                end else if (r_p0 >= PW'(att_pkg::ROWS)) begin
                    n_row = RW'(att_pkg::ROWS - 1);
                end else begin
                    n_row = RW'(r_p0 - PW'(1));
                end
                if (r_pcnt <= att_pkg::PCNT_W'(1) || pv <= PW'(1)) begin
                    n_col = '0;
                end else if (pv >= PW'(att_pkg::COLUMNS)) begin
                    n_col = CW'(att_pkg::COLUMNS - 1);
                end else begin
                    n_col = CW'(pv - PW'(1));
                end
                n_state = att_pkg::S_RESULT;
            end
            att_pkg::S_J_RD: begin
                n_state = att_pkg::S_J_AP;
            end
            att_pkg::S_J_AP: begin
                n_state = att_pkg::S_RESULT;
                if (r_pcnt > '0 && (pv == PW'(2) || pv == PW'(3))) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_ptr   = '0;
                    n_end   = AW'(att_pkg::CELLS - 1);
                    n_state = att_pkg::S_FILL;
                end
            end
            default: n_state = att_pkg::S_IDLE;
        endcase
    end

    assign o_cmd            = cmd;
    assign rsp.valid        = (r_state == att_pkg::S_RESULT);
    assign rsp.cell_data    = r_data;
    assign rsp.cursor_index = 11'(att_pkg::cell_addr(r_row, r_col));
    assign rsp.in_escape    = (r_mode != att_pkg::MODE_NORMAL);
endmodule

[src/ansi_text_terminal_unit.sv]
// Top level: ANSI text terminal engine, controller plus screen datapath.
//
//  channel  dir  payload                                  handshake
//  i_req    in   req_type, char_byte, cell_index          valid/ready
//  o_rsp    out  cell_data, cursor_index, in_escape       valid/ready
//
// Bytes pass the accept and result states; reads of a screen cell add S_READ
// (registered RAM read). Cursor position adds S_H_RD0, S_H_RD1 and S_H_AP; a colour
// list fetches and applies each parameter. A scroll moves rows 1 to ROWS-1 up
// and blanks the bottom row; clear blanks every cell, erase-line the cursor's row
// to its end. After reset a clearing pass writes every cell before the first item
// is taken. A result waits in its register until taken and holds off the next item.
module ansi_text_terminal_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    att_req_if.sink   i_req,
    att_rsp_if.source o_rsp
);
    att_pkg::t_dp_cmd  cmd;
    att_pkg::t_dp_stat stat;

    att_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .req    (i_req),
        .rsp    (o_rsp),
        .o_cmd  (cmd),
        .i_stat (stat)
    );

    att_datapath u_dp (
        .i_clk (i_clk),
        .i_cmd (cmd),
        .o_stat(stat)
    );
endmodule
